FILE: design/tat_pkg.sv
// Shared types and codes for the transaction tag allocator.
package tat_pkg;

	localparam logic [1:0] MODE_ALLOC   = 2'd0;
	localparam logic [1:0] MODE_RESP    = 2'd1;
	localparam logic [1:0] MODE_CLEAR   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_UNKNOWN   = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] buffer_address;
		logic [15:0] tag_in;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  tag_out;
		logic [31:0] address_out;
		logic [6:0]  pending;
	} res_t;

endpackage

FILE: design/transaction_tag_allocator_unit.sv
// Outstanding-transaction tag table: allocate, response lookup/release and clear.
//
// A request is transferred at a clock edge with start high and busy low. Each
// request first reads the stored address from the address memory into a register
// at the transfer; the execute state then updates the busy bitmap, the pending
// count and, on allocate, writes the memory. The result follows with done high
// for one cycle, and a new request may be transferred in that same cycle, but no
// request is taken while one is in the execute state. The lowest free tag is
// found by a priority encode over the busy bitmap. There is no clearing pass
// after reset; the bitmap resets at once. The receiver cannot stall: every
// result must be taken in the cycle done is high.
module transaction_tag_allocator_unit #(
	parameter int LOG_DEPTH = 64,
	parameter int ADDR_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tat_pkg::req_t req,
	output logic          done,
	output tat_pkg::res_t res
);
	import tat_pkg::*;

	localparam int IW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int CW = $clog2(LOG_DEPTH + 1);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t                 state_q;
	logic [LOG_DEPTH-1:0]   tag_busy_q;
	logic [CW-1:0]          count_q;
	logic                   done_q;
	res_t                   res_q;

	req_t                   req_s1;
	logic [ADDR_BITS-1:0]   rd_data_s1;
	logic [ADDR_BITS-1:0]   addr_mem [LOG_DEPTH];

	logic                   accept;
	logic                   free_found;
	logic [IW-1:0]          free_idx;
	logic [IW-1:0]          resp_idx;
	logic                   resp_hit;
	logic                   mem_we;
	logic [LOG_DEPTH-1:0]   busy_next;
	logic [CW-1:0]          count_next;
	res_t                   res_next;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign res      = res_q;
	assign resp_idx = req_s1.tag_in[IW-1:0];
	assign resp_hit = ({1'b0, req_s1.tag_in} < 17'(LOG_DEPTH)) && tag_busy_q[resp_idx];

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = LOG_DEPTH - 1; i >= 0; i--) begin
			if (!tag_busy_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	always_comb begin
		busy_next           = tag_busy_q;
		count_next          = count_q;
		mem_we              = 1'b0;
		res_next.status     = ST_OK;
		res_next.tag_out    = '0;
		res_next.address_out = '0;
		unique case (req_s1.mode)
			MODE_ALLOC: begin
				if (free_found) begin
					busy_next[free_idx] = 1'b1;
					count_next          = count_q + 1'b1;
					mem_we              = 1'b1;
					res_next.tag_out    = 6'(free_idx);
				end else begin
					res_next.status = ST_FULL;
				end
			end
			MODE_RESP: begin
				if (resp_hit) begin
					busy_next[resp_idx]  = 1'b0;
					count_next           = count_q - 1'b1;
					res_next.address_out = 32'(rd_data_s1);
				end else begin
					res_next.status = ST_UNKNOWN;
				end
			end
			MODE_CLEAR: begin
				busy_next  = '0;
				count_next = '0;
			end
			default: ;
		endcase
		res_next.pending = 7'(count_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			tag_busy_q <= '0;
			count_q    <= '0;
			done_q     <= 1'b0;
			res_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					tag_busy_q <= busy_next;
					count_q    <= count_next;
					res_q      <= res_next;
					done_q     <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	// address memory: read on transfer, write in the execute cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_data_s1 <= addr_mem[req.tag_in[IW-1:0]];
		end
		if (mem_we && (state_q == S_EXEC)) begin
			addr_mem[free_idx] <= ADDR_BITS'(req_s1.buffer_address);
		end
	end

endmodule

FILE: design/tat_checker.sv
// Port-level checker for the transaction tag allocator, with its bind.
module tat_checker #(
	parameter int LOG_DEPTH = 64
) (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input tat_pkg::req_t req,
	input logic          done,
	input tat_pkg::res_t res
);
	import tat_pkg::*;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request in progress");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.mode == MODE_CLEAR) |=> ##1
		(done && res.pending == 7'd0 && res.status == ST_OK))
		else $error("clear did not report an empty table");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.status == ST_FULL) |-> (res.pending == 7'(LOG_DEPTH) && res.tag_out == 6'd0))
		else $error("full reported with free tags");

	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.status == ST_UNKNOWN) |-> (res.address_out == 32'd0))
		else $error("unknown tag returned an address");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results closer than one request apart");

endmodule

bind transaction_tag_allocator_unit tat_checker #(.LOG_DEPTH(LOG_DEPTH)) u_tat_checker (.*);

FILE: tb/transaction_tag_allocator_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for transaction_tag_allocator_unit: tag traffic checked against a behavioral tag table.
module transaction_tag_allocator_unit_tb;
	import tat_pkg::*;

	localparam int NUM_TAGS = 64;
	localparam int NUM_ITEMS = 1450;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 10;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		req_t        r;
		int unsigned gap;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	res_t res;

	stim_t stim_q[$];
	res_t  expected_q[$];

	// occupancy as the stimulus generator sees it, used to aim responses at live tags
	bit          gen_busy[NUM_TAGS];
	bit          no_idle;
	int unsigned n_gen;

	// predicted tag table
	bit          tbl_busy[NUM_TAGS];
	logic [31:0] tbl_addr[NUM_TAGS];
	int unsigned tbl_count;

	bit          presenting;
	bit          gap_loaded;
	int unsigned wait_left;
	int unsigned mismatches;
	int unsigned cycles;

	transaction_tag_allocator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.res    (res)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic res_t table_step(req_t r);
		res_t o;
		bit   found;
		o = '0;
		o.status = ST_OK;
		found = 1'b0;
		case (r.mode)
		MODE_ALLOC: begin
			o.status = ST_FULL;
			for (int i = 0; i < NUM_TAGS; i++) begin
				if (!found && !tbl_busy[i]) begin
					found = 1'b1;
					tbl_busy[i] = 1'b1;
					tbl_addr[i] = r.buffer_address;
					tbl_count++;
					o.status = ST_OK;
					o.tag_out = 6'(i);
				end
			end
		end
		MODE_RESP: begin
			if (r.tag_in < NUM_TAGS && tbl_busy[r.tag_in[5:0]]) begin
				o.address_out = tbl_addr[r.tag_in[5:0]];
				tbl_busy[r.tag_in[5:0]] = 1'b0;
				if (tbl_count > 0)
					tbl_count--;
			end else begin
				o.status = ST_UNKNOWN;
			end
		end
		MODE_CLEAR: begin
			foreach (tbl_busy[i])
				tbl_busy[i] = 1'b0;
			tbl_count = 0;
		end
		default: ;
		endcase
		o.pending = 7'(tbl_count);
		return o;
	endfunction

	task automatic push_item(logic [1:0] m, logic [31:0] a, logic [15:0] t);
		stim_t s;
		bit    found;
		s.r.mode = m;
		s.r.buffer_address = a;
		s.r.tag_in = t;
		s.gap = no_idle ? 0 : $urandom_range(0, 6);
		stim_q.push_back(s);
		n_gen++;
		found = 1'b0;
		case (m)
		MODE_ALLOC: begin
			for (int i = 0; i < NUM_TAGS; i++) begin
				if (!found && !gen_busy[i]) begin
					gen_busy[i] = 1'b1;
					found = 1'b1;
				end
			end
		end
		MODE_RESP: begin
			if (t < NUM_TAGS)
				gen_busy[t[5:0]] = 1'b0;
		end
		MODE_CLEAR: begin
			foreach (gen_busy[i])
				gen_busy[i] = 1'b0;
		end
		default: ;
		endcase
	endtask

	function automatic int pick_busy_tag();
		int live[$];
		for (int i = 0; i < NUM_TAGS; i++)
			if (gen_busy[i])
				live.push_back(i);
		if (live.size() == 0)
			return -1;
		return live[$urandom_range(0, live.size() - 1)];
	endfunction

	function automatic bit table_full();
		foreach (gen_busy[i])
			if (!gen_busy[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [31:0] rand_addr();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 32'h0;
		if (pick == 1)
			return 32'hFFFF_FFFF;
		return $urandom();
	endfunction

	function automatic logic [15:0] rand_tag();
		if ($urandom_range(0, 1) == 0)
			return 16'($urandom_range(0, NUM_TAGS + 3));
		return 16'($urandom());
	endfunction

	initial begin
		int kind;
		int t;
		no_idle = 1'b0;

		// empty table, unknown and out-of-range tags
		push_item(MODE_RESP, 32'h0, 16'd0);
		push_item(MODE_RESP, 32'hFFFF_FFFF, 16'hFFFF);
		push_item(MODE_RESP, 32'h0, 16'd64);
		// zero address stored and returned
		push_item(MODE_ALLOC, 32'h0, 16'hFFFF);
		push_item(MODE_ALLOC, 32'hFFFF_FFFF, 16'd0);
		push_item(MODE_ALLOC, 32'hA5A5_5A5A, 16'd0);
		push_item(MODE_RESP, 32'h0, 16'd0);
		push_item(MODE_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
		push_item(MODE_ALLOC, 32'h1234_5678, 16'd0);
		push_item(MODE_RESP, 32'h0, 16'd1);
		push_item(MODE_RESP, 32'h0, 16'd1);
		push_item(MODE_RESP, 32'h0, 16'd63);
		push_item(MODE_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
		push_item(MODE_RESP, 32'h0, 16'd0);
		push_item(MODE_UNUSED, 32'h0, 16'h0);
		// fill to full, overflow, free the top tag, clear from full
		repeat (NUM_TAGS)
			push_item(MODE_ALLOC, $urandom(), 16'($urandom()));
		push_item(MODE_ALLOC, 32'hFFFF_FFFF, 16'hFFFF);
		push_item(MODE_RESP, 32'h0, 16'd63);
		push_item(MODE_ALLOC, 32'h0, 16'h0);
		push_item(MODE_ALLOC, 32'h0, 16'h0);
		push_item(MODE_UNUSED, 32'h0, 16'h0);
		push_item(MODE_CLEAR, 32'h0, 16'h0);

		while (n_gen < NUM_ITEMS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				repeat ($urandom_range(8, 40)) begin
					t = pick_busy_tag();
					if (t >= 0 && $urandom_range(0, 99) < 45)
						push_item(MODE_RESP, $urandom(), 16'(t));
					else if ($urandom_range(0, 99) < 85)
						push_item(MODE_ALLOC, rand_addr(), 16'($urandom()));
					else
						push_item(MODE_RESP, $urandom(), rand_tag());
				end
			end else if (kind < 62) begin
				while (!table_full())
					push_item(MODE_ALLOC, rand_addr(), 16'($urandom()));
				repeat ($urandom_range(1, 3))
					push_item(MODE_ALLOC, rand_addr(), 16'($urandom()));
			end else if (kind < 82) begin
				t = pick_busy_tag();
				while (t >= 0) begin
					push_item(MODE_RESP, $urandom(), 16'(t));
					if ($urandom_range(0, 9) == 0)
						push_item(MODE_RESP, $urandom(), rand_tag());
					t = pick_busy_tag();
				end
			end else if (kind < 92) begin
				push_item(MODE_CLEAR, $urandom(), 16'($urandom()));
			end else begin
				repeat ($urandom_range(2, 8)) begin
					if ($urandom_range(0, 9) == 0)
						push_item(MODE_UNUSED, $urandom(), 16'($urandom()));
					else
						push_item(MODE_RESP, $urandom(), rand_tag());
				end
			end
		end

		while (stim_q.size() != 0 || start || expected_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// driver: one request per transfer, optional gap before each
	always @(posedge clk or negedge arst_n) begin
		stim_t cur;
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			presenting = 1'b0;
			gap_loaded = 1'b0;
			wait_left = 0;
			foreach (tbl_busy[i])
				tbl_busy[i] = 1'b0;
			tbl_count = 0;
		end else begin
			if (start && !busy) begin
				expected_q.push_back(table_step(req));
				presenting = 1'b0;
			end
			if (!presenting && stim_q.size() != 0) begin
				if (!gap_loaded) begin
					wait_left = stim_q[0].gap;
					gap_loaded = 1'b1;
				end
				if (wait_left == 0) begin
					cur = stim_q.pop_front();
					req <= cur.r;
					start <= 1'b1;
					presenting = 1'b1;
					gap_loaded = 1'b0;
				end else begin
					wait_left--;
				end
			end
			if (!presenting)
				start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with none expected: status=%0d tag=%0d addr=%h pending=%0d",
						res.status, res.tag_out, res.address_out, res.pending);
			end else begin
				want = expected_q.pop_front();
				if (res.status !== want.status || res.tag_out !== want.tag_out ||
						res.address_out !== want.address_out || res.pending !== want.pending) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp status=%0d tag=%0d addr=%h pending=%0d, ",
							"got status=%0d tag=%0d addr=%h pending=%0d"},
							want.status, want.tag_out, want.address_out, want.pending,
							res.status, res.tag_out, res.address_out, res.pending);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
